FILE: rtl/core/qhd_pkg.sv
// Package for the QAM hard demapper: widths, codes, types and threshold constants.
package qhd_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int FRAC_BITS    = 12;

	localparam int K_WIDTH    = 31;
	localparam int PROD_WIDTH = SAMPLE_WIDTH + K_WIDTH;
	localparam int RND_WIDTH  = PROD_WIDTH + 1;
	localparam int HMAG_WIDTH = SAMPLE_WIDTH + 1;
	localparam int SLC_WIDTH  = SAMPLE_WIDTH + 4;

	localparam int CFG_IDX_WIDTH  = 2;
	localparam int CFG_DATA_WIDTH = 2;
	localparam int BITS_WIDTH     = 8;
	localparam int COUNT_WIDTH    = 4;

	typedef logic signed [SAMPLE_WIDTH-1:0] smp_t;
	typedef logic [SAMPLE_WIDTH-1:0]        umag_t;

	typedef enum logic [1:0] {
		MOD_QPSK   = 2'd0,
		MOD_QAM16  = 2'd1,
		MOD_QAM64  = 2'd2,
		MOD_QAM256 = 2'd3
	} mod_t;

	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		CFG_MOD_ORDER = 2'd0,
		CFG_USE_CSI   = 2'd1
	} cfg_idx_t;

	typedef struct packed {
		mod_t mod_order;
		logic use_csi;
	} cfg_t;

	// thresholds in units of the spacing: slot 3 is h3 for 64-QAM, h4 for 256-QAM
	typedef struct packed {
		smp_t h1;
		smp_t h2;
		smp_t h3;
	} thr_t;

	typedef struct packed {
		umag_t xm;
		umag_t ym;
		logic  xneg;
		logic  yneg;
		logic  yzero;
		thr_t  thr;
	} slc_in_t;

	// k*2/sqrt(M') in unsigned Q0.31
	localparam logic [K_WIDTH-1:0] K10_1  = 31'd1358187913;
	localparam logic [K_WIDTH-1:0] K42_1  = 31'd662727842;
	localparam logic [K_WIDTH-1:0] K42_2  = 31'd1325455684;
	localparam logic [K_WIDTH-1:0] K42_3  = 31'd1988183525;
	localparam logic [K_WIDTH-1:0] K170_1 = 31'd329408954;
	localparam logic [K_WIDTH-1:0] K170_2 = 31'd658817909;
	localparam logic [K_WIDTH-1:0] K170_4 = 31'd1317635818;

	localparam logic [SAMPLE_WIDTH-1:0] GAIN_ONE =
		{{(SAMPLE_WIDTH-1){1'b0}}, 1'b1} << FRAC_BITS;
	localparam logic [HMAG_WIDTH-1:0] HMAG_POS_MAX = {2'b00, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic [HMAG_WIDTH-1:0] HMAG_NEG_MAX = {2'b01, {(SAMPLE_WIDTH-1){1'b0}}};
	localparam smp_t SMP_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam smp_t SMP_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
	localparam logic [RND_WIDTH-1:0] RND_HALF = {{(RND_WIDTH-1){1'b0}}, 1'b1} << (K_WIDTH - 1);

	localparam logic [COUNT_WIDTH-1:0] CNT_QPSK   = 4'd2;
	localparam logic [COUNT_WIDTH-1:0] CNT_QAM16  = 4'd4;
	localparam logic [COUNT_WIDTH-1:0] CNT_QAM64  = 4'd6;
	localparam logic [COUNT_WIDTH-1:0] CNT_QAM256 = 4'd8;

endpackage

FILE: rtl/core/qhd_sym_if.sv
// Symbol input channel: valid/ready with I, Q, channel gain and packet end.
interface qhd_sym_if import qhd_pkg::*; ();
	logic valid;
	logic ready;
	smp_t sample_i;
	smp_t sample_q;
	smp_t chan_gain;
	logic end_of_packet;

	modport source (output valid, sample_i, sample_q, chan_gain, end_of_packet, input ready);
	modport sink   (input valid, sample_i, sample_q, chan_gain, end_of_packet, output ready);
endinterface

FILE: rtl/core/qhd_res_if.sv
// Result channel: valid/ready with decided bits, bit count and packet end.
interface qhd_res_if import qhd_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [BITS_WIDTH-1:0]  bits;
	logic [COUNT_WIDTH-1:0] bit_count;
	logic                   end_out;

	modport source (output valid, bits, bit_count, end_out, input ready);
	modport sink   (input valid, bits, bit_count, end_out, output ready);
endinterface

FILE: rtl/core/qhd_cfg_if.sv
// Configuration write channel: valid/ready with register index and data.
interface qhd_cfg_if import qhd_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [CFG_IDX_WIDTH-1:0]  index;
	logic [CFG_DATA_WIDTH-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/qhd_cfg.sv
// Configuration register bank: modulation order and CSI enable.
module qhd_cfg import qhd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	qhd_cfg_if.sink    cfg,
	output cfg_t       cfg_out
);

	cfg_t cfg_q;

	assign cfg.ready = 1'b1;
	assign cfg_out   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mod_order <= MOD_QPSK;
			cfg_q.use_csi   <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_MOD_ORDER: cfg_q.mod_order <= mod_t'(cfg.data[1:0]);
				CFG_USE_CSI:   cfg_q.use_csi   <= cfg.data[0];
				default: ;
			endcase
		end
	end

endmodule

FILE: rtl/core/qhd_thresh.sv
// Threshold unit: |g| times the spacing factors, rounded, signed and saturated.
module qhd_thresh import qhd_pkg::*; (
	input  mod_t  mod_order,
	input  umag_t gmag,
	input  logic  gneg,
	output thr_t  thr
);

	logic [K_WIDTH-1:0]    k [3];
	logic [PROD_WIDTH-1:0] prod [3];
	logic [RND_WIDTH-1:0]  rnd [3];
	logic [HMAG_WIDTH-1:0] hmag [3];
	logic [HMAG_WIDTH-1:0] hneg [3];
	smp_t                  h [3];

	always_comb begin
		case (mod_order)
			MOD_QAM16: begin
				k[0] = K10_1;  k[1] = K10_1;  k[2] = K10_1;
			end
			MOD_QAM64: begin
				k[0] = K42_1;  k[1] = K42_2;  k[2] = K42_3;
			end
			MOD_QAM256: begin
				k[0] = K170_1; k[1] = K170_2; k[2] = K170_4;
			end
			default: begin
				k[0] = '0;     k[1] = '0;     k[2] = '0;
			end
		endcase
	end

	for (genvar i = 0; i < 3; i++) begin : g_thr
		assign prod[i] = PROD_WIDTH'(gmag) * PROD_WIDTH'(k[i]);
		// round half away from zero on the magnitude
		assign rnd[i]  = {1'b0, prod[i]} + RND_HALF;
		assign hmag[i] = rnd[i][RND_WIDTH-1:K_WIDTH];
		assign hneg[i] = ~hmag[i] + HMAG_WIDTH'(1);

		always_comb begin
			if (!gneg)
				h[i] = (hmag[i] > HMAG_POS_MAX) ? SMP_MAX : smp_t'(hmag[i][SAMPLE_WIDTH-1:0]);
			else
				h[i] = (hmag[i] > HMAG_NEG_MAX) ? SMP_MIN : smp_t'(hneg[i][SAMPLE_WIDTH-1:0]);
		end
	end

	assign thr.h1 = h[0];
	assign thr.h2 = h[1];
	assign thr.h3 = h[2];

endmodule

FILE: rtl/core/qhd_slicer.sv
// Slicer: Gray-coded bit decisions from magnitudes, signs and thresholds.
module qhd_slicer import qhd_pkg::*; (
	input  mod_t                   mod_order,
	input  slc_in_t                slc,
	output logic [BITS_WIDTH-1:0]  bits,
	output logic [COUNT_WIDTH-1:0] bit_count
);

	typedef logic signed [SLC_WIDTH-1:0] wide_t;

	function automatic wide_t sabs(input wide_t v);
		return v[SLC_WIDTH-1] ? -v : v;
	endfunction

	function automatic wide_t ext_u(input umag_t v);
		return $signed({{(SLC_WIDTH-SAMPLE_WIDTH){1'b0}}, v});
	endfunction

	function automatic wide_t ext_s(input smp_t v);
		return $signed({{(SLC_WIDTH-SAMPLE_WIDTH){v[SAMPLE_WIDTH-1]}}, v});
	endfunction

	wide_t xm, ym, h1, h2, h3;
	wide_t dx, dy, ex, ey;

	assign xm = ext_u(slc.xm);
	assign ym = ext_u(slc.ym);
	assign h1 = ext_s(slc.thr.h1);
	assign h2 = ext_s(slc.thr.h2);
	assign h3 = ext_s(slc.thr.h3);

	// 256-QAM folds: distance to h4, then to h2
	assign dx = sabs(xm - h3);
	assign dy = sabs(ym - h3);
	assign ex = sabs(dx - h2);
	assign ey = sabs(dy - h2);

	always_comb begin
		case (mod_order)
			MOD_QAM16: begin
				bits = {4'b0000, !slc.xneg, xm <= h1, slc.yneg, ym <= h1};
				bit_count = CNT_QAM16;
			end
			MOD_QAM64: begin
				bits = {2'b00,
					!slc.xneg, xm <= h2, (xm >= h1) && (xm <= h3),
					slc.yneg,  ym <= h2, (ym >= h1) && (ym <= h3)};
				bit_count = CNT_QAM64;
			end
			MOD_QAM256: begin
				// Q sign bit is also set on zero
				bits = {!slc.xneg, xm <= h3, dx <= h2, ex <= h1,
					slc.yneg || slc.yzero, ym <= h3, dy <= h2, ey <= h1};
				bit_count = CNT_QAM256;
			end
			default: begin
				bits = {6'b000000, !slc.xneg, slc.yneg};
				bit_count = CNT_QPSK;
			end
		endcase
	end

endmodule

FILE: rtl/core/qam_hard_demapper.sv
// Latency: an accepted item passes the input, threshold and result regs before its result shows on res.
// Throughput: one item per cycle; the three-stage pipeline stalls as a whole only when
// a result sits on res and res.ready is low, so the multipliers in the threshold stage
// set the clock, not the rate.
// Reset: arst_n clears the stage valids and sets QPSK with CSI off.
module qam_hard_demapper import qhd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	qhd_cfg_if.sink   cfg,
	qhd_sym_if.sink   sym,
	qhd_res_if.source res
);

	cfg_t cfg_cur;

	logic  adv;
	logic  v_s1, v_s2, v_s3;
	smp_t  x_s1, y_s1;
	umag_t gmag_s1;
	logic  gneg_s1;
	logic  eop_s1, eop_s2, eop_s3;

	smp_t    gsel;
	umag_t   gmag;
	thr_t    thr;
	slc_in_t slc_nxt, slc_s2;

	logic [BITS_WIDTH-1:0]  bits_nxt, bits_s3;
	logic [COUNT_WIDTH-1:0] cnt_nxt, cnt_s3;

	qhd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cfg_out (cfg_cur)
	);

	// whole pipe moves unless the held result is stalled
	assign adv       = !v_s3 || res.ready;
	assign sym.ready = adv;

	assign gsel = cfg_cur.use_csi ? sym.chan_gain : smp_t'(GAIN_ONE);
	assign gmag = gsel[SAMPLE_WIDTH-1] ? umag_t'(~gsel + smp_t'(1)) : umag_t'(gsel);

	qhd_thresh u_thresh (
		.mod_order (cfg_cur.mod_order),
		.gmag      (gmag_s1),
		.gneg      (gneg_s1),
		.thr       (thr)
	);

	always_comb begin
		slc_nxt.xm    = x_s1[SAMPLE_WIDTH-1] ? umag_t'(~x_s1 + smp_t'(1)) : umag_t'(x_s1);
		slc_nxt.ym    = y_s1[SAMPLE_WIDTH-1] ? umag_t'(~y_s1 + smp_t'(1)) : umag_t'(y_s1);
		slc_nxt.xneg  = x_s1[SAMPLE_WIDTH-1];
		slc_nxt.yneg  = y_s1[SAMPLE_WIDTH-1];
		slc_nxt.yzero = (y_s1 == '0);
		slc_nxt.thr   = thr;
	end

	qhd_slicer u_slicer (
		.mod_order (cfg_cur.mod_order),
		.slc       (slc_s2),
		.bits      (bits_nxt),
		.bit_count (cnt_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= sym.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1    <= sym.sample_i;
			y_s1    <= sym.sample_q;
			gmag_s1 <= gmag;
			gneg_s1 <= gsel[SAMPLE_WIDTH-1];
			eop_s1  <= sym.end_of_packet;
			slc_s2  <= slc_nxt;
			eop_s2  <= eop_s1;
			bits_s3 <= bits_nxt;
			cnt_s3  <= cnt_nxt;
			eop_s3  <= eop_s2;
		end
	end

	assign res.valid     = v_s3;
	assign res.bits      = bits_s3;
	assign res.bit_count = cnt_s3;
	assign res.end_out   = eop_s3;

endmodule

FILE: rtl/core/qhd_checker.sv
// Port-level checks for the QAM hard demapper, bound to the top level.
module qhd_checker import qhd_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   sym_valid,
	input logic                   sym_ready,
	input logic                   res_valid,
	input logic                   res_ready,
	input logic [BITS_WIDTH-1:0]  res_bits,
	input logic [COUNT_WIDTH-1:0] res_bit_count,
	input logic                   res_end_out
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_bits)
			&& $stable(res_bit_count) && $stable(res_end_out))
		else $error("result changed while stalled");

	a_count_legal: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_bit_count == CNT_QPSK || res_bit_count == CNT_QAM16
			|| res_bit_count == CNT_QAM64 || res_bit_count == CNT_QAM256)
		else $error("illegal bit count");

	a_high_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_bits >> res_bit_count) == '0)
		else $error("bits above bit count not zero");

	// with the sink ready throughout, an accepted item comes out once it has passed the input, threshold and result regs
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$past(sym_valid && sym_ready, 3) && $past(res_ready, 1) && $past(res_ready, 2)
			&& $past(arst_n, 1) && $past(arst_n, 2) && $past(arst_n, 3) |-> res_valid)
		else $error("result missing after pipeline latency");

endmodule

bind qam_hard_demapper qhd_checker u_qhd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.sym_valid     (sym.valid),
	.sym_ready     (sym.ready),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.res_bits      (res.bits),
	.res_bit_count (res.bit_count),
	.res_end_out   (res.end_out)
);

FILE: test/qam_hard_demapper_tb.sv
// Testbench for qam_hard_demapper: directed and random symbols under all settings.
`timescale 1ns / 100ps

module qam_hard_demapper_tb;
	import qhd_pkg::*;

	// spacing factors k*2/sqrt(M') in unsigned Q0.31
	localparam longint K16_H1  = 1358187913;
	localparam longint K64_H1  = 662727842;
	localparam longint K64_H2  = 1325455684;
	localparam longint K64_H3  = 1988183525;
	localparam longint K256_H1 = 329408954;
	localparam longint K256_H2 = 658817909;
	localparam longint K256_H4 = 1317635818;

	localparam longint SAT_HI     = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1;
	localparam longint SAT_LO     = -SAT_HI - 1;
	localparam longint GAIN_UNITY = 64'sd1 <<< FRAC_BITS;

	localparam logic [CFG_IDX_WIDTH-1:0] CFG_IDX_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_IDX_SPARE_B = 2'd3;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int ITEMS_PER_SETTING = 31;

	typedef struct {
		logic [BITS_WIDTH-1:0]  bits;
		logic [COUNT_WIDTH-1:0] count;
		logic                   eop;
	} decision_t;

	class demap_scoreboard;
		mod_t      mod_order;
		logic      use_csi;
		decision_t expected_q[$];
		int        errors;

		function new();
			mod_order = MOD_QPSK;
			use_csi   = 1'b0;
			errors    = 0;
		endfunction

		static function longint magnitude(longint v);
			return (v < 0) ? -v : v;
		endfunction

		// rounded half away from zero, then clipped to the sample range
		static function longint thr(longint g, longint k);
			longint h;
			h = (magnitude(g) * k + (64'sd1 <<< 30)) >>> 31;
			if (g < 0)
				h = -h;
			if (h > SAT_HI)
				h = SAT_HI;
			if (h < SAT_LO)
				h = SAT_LO;
			return h;
		endfunction

		function void write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] data);
			case (idx)
				CFG_MOD_ORDER: mod_order = mod_t'(data);
				CFG_USE_CSI:   use_csi = data[0];
				default: ;
			endcase
		endfunction

		function decision_t decide(smp_t x, smp_t y, smp_t g_in, logic eop);
			longint    xl, yl, g, xm, ym, h1, h2, h3, dx, dy;
			logic [BITS_WIDTH-1:0] b;
			decision_t r;
			xl = longint'(x);
			yl = longint'(y);
			g  = use_csi ? longint'(g_in) : GAIN_UNITY;
			xm = magnitude(xl);
			ym = magnitude(yl);
			b  = '0;
			case (mod_order)
				MOD_QPSK: begin
					b[0] = yl < 0;
					b[1] = xl >= 0;
				end
				MOD_QAM16: begin
					h1 = thr(g, K16_H1);
					b[0] = ym <= h1;
					b[1] = yl < 0;
					b[2] = xm <= h1;
					b[3] = xl >= 0;
				end
				MOD_QAM64: begin
					h1 = thr(g, K64_H1);
					h2 = thr(g, K64_H2);
					h3 = thr(g, K64_H3);
					b[0] = (ym >= h1) && (ym <= h3);
					b[1] = ym <= h2;
					b[2] = yl < 0;
					b[3] = (xm >= h1) && (xm <= h3);
					b[4] = xm <= h2;
					b[5] = xl >= 0;
				end
				default: begin
					h1 = thr(g, K256_H1);
					h2 = thr(g, K256_H2);
					h3 = thr(g, K256_H4);
					dy = magnitude(ym - h3);
					dx = magnitude(xm - h3);
					b[0] = magnitude(dy - h2) <= h1;
					b[1] = dy <= h2;
					b[2] = ym <= h3;
					b[3] = yl <= 0;   // zero counts as negative on Q only
					b[4] = magnitude(dx - h2) <= h1;
					b[5] = dx <= h2;
					b[6] = xm <= h3;
					b[7] = xl >= 0;
				end
			endcase
			r.bits  = b;
			r.count = COUNT_WIDTH'(2 * (int'(mod_order) + 1));
			r.eop   = eop;
			return r;
		endfunction

		function void note_symbol(smp_t x, smp_t y, smp_t g, logic eop);
			expected_q.push_back(decide(x, y, g, eop));
		endfunction

		function void check_result(logic [BITS_WIDTH-1:0] bits, logic [COUNT_WIDTH-1:0] count,
				logic eop);
			decision_t e;
			if (expected_q.size() == 0) begin
				$error("unexpected result: bits %h bit_count %0d end_out %b", bits, count, eop);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (bits !== e.bits) begin
				$error("bits: expected %h, got %h", e.bits, bits);
				errors++;
			end
			if (count !== e.count) begin
				$error("bit_count: expected %0d, got %0d", e.count, count);
				errors++;
			end
			if (eop !== e.eop) begin
				$error("end_out: expected %b, got %b", e.eop, eop);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   tx_idle_pct;
	int   rx_idle_pct;
	int   quiet_cycles;
	demap_scoreboard sb;

	qhd_cfg_if cfg_bus();
	qhd_sym_if sym_bus();
	qhd_res_if res_bus();

	qam_hard_demapper dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.sym    (sym_bus),
		.res    (res_bus)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		res_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			res_bus.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// handshake monitor, predictor feed and watchdog
	always @(posedge clk) begin
		if (cfg_bus.valid && cfg_bus.ready)
			sb.write_reg(cfg_bus.index, cfg_bus.data);
		if (sym_bus.valid && sym_bus.ready)
			sb.note_symbol(sym_bus.sample_i, sym_bus.sample_q, sym_bus.chan_gain,
				sym_bus.end_of_packet);
		if (res_bus.valid && res_bus.ready)
			sb.check_result(res_bus.bits, res_bus.bit_count, res_bus.end_out);
		if ((cfg_bus.valid && cfg_bus.ready) || (sym_bus.valid && sym_bus.ready)
				|| (res_bus.valid && res_bus.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic cfg_write(input logic [CFG_IDX_WIDTH-1:0] idx,
			input logic [CFG_DATA_WIDTH-1:0] data);
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= data;
		do @(posedge clk); while (cfg_bus.ready !== 1'b1);
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic send_sym(input smp_t i_v, input smp_t q_v, input smp_t g_v, input logic eop_v);
		@(negedge clk);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			sym_bus.valid <= 1'b0;
			@(negedge clk);
		end
		sym_bus.valid         <= 1'b1;
		sym_bus.sample_i      <= i_v;
		sym_bus.sample_q      <= q_v;
		sym_bus.chan_gain     <= g_v;
		sym_bus.end_of_packet <= eop_v;
		do @(posedge clk); while (sym_bus.ready !== 1'b1);
	endtask

	task automatic sym_stop();
		@(negedge clk);
		sym_bus.valid <= 1'b0;
	endtask

	task automatic drain();
		while (sb.expected_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic smp_t rand_gain();
		longint g;
		case ($urandom_range(0, 5))
			0, 1: g = longint'($urandom_range(2048, 8192));
			2: g = -longint'($urandom_range(2048, 8192));
			3: g = longint'(smp_t'($urandom));
			4: g = 0;
			default: begin
				case ($urandom_range(0, 3))
					0: g = SAT_HI;
					1: g = SAT_LO;
					2: g = 1;
					default: g = -1;
				endcase
			end
		endcase
		return smp_t'(g);
	endfunction

	// mostly values near the decision boundaries of the current constellation
	function automatic smp_t rand_sample(mod_t m, longint g);
		longint t1, t2, t3, v, span;
		t1 = 0;
		t2 = 0;
		t3 = 0;
		case (m)
			MOD_QAM16: t1 = demap_scoreboard::thr(g, K16_H1);
			MOD_QAM64: begin
				t1 = demap_scoreboard::thr(g, K64_H1);
				t2 = demap_scoreboard::thr(g, K64_H2);
				t3 = demap_scoreboard::thr(g, K64_H3);
			end
			MOD_QAM256: begin
				t1 = demap_scoreboard::thr(g, K256_H1);
				t2 = demap_scoreboard::thr(g, K256_H2);
				t3 = demap_scoreboard::thr(g, K256_H4);
			end
			default: ;
		endcase
		span = 3 * demap_scoreboard::magnitude(g) + 64;
		case ($urandom_range(0, 3))
			0: v = longint'(smp_t'($urandom));
			1: v = longint'($urandom_range(0, span)) - span / 2;
			2: begin
				v = t3 * longint'($urandom_range(0, 1))
					+ t2 * (longint'($urandom_range(0, 2)) - 1)
					+ t1 * (longint'($urandom_range(0, 2)) - 1)
					+ (longint'($urandom_range(0, 2)) - 1);
				if ($urandom_range(0, 1))
					v = -v;
			end
			default: begin
				case ($urandom_range(0, 4))
					0: v = SAT_LO;
					1: v = SAT_HI;
					2: v = 0;
					3: v = -1;
					default: v = 1;
				endcase
			end
		endcase
		if (v > SAT_HI)
			v = SAT_HI;
		if (v < SAT_LO)
			v = SAT_LO;
		return smp_t'(v);
	endfunction

	task automatic random_burst(input mod_t m, input logic csi, input int n);
		int   k;
		int   pause_at;
		smp_t g;
		pause_at = $urandom_range(0, n - 1);
		for (k = 0; k < n; k++) begin
			if (k == pause_at) begin
				sym_stop();
				drain();
			end
			g = rand_gain();
			send_sym(rand_sample(m, csi ? longint'(g) : GAIN_UNITY),
				rand_sample(m, csi ? longint'(g) : GAIN_UNITY), g, 1'($urandom));
		end
		sym_stop();
	endtask

	initial begin
		int     mode;
		int     mi;
		int     csi;
		mod_t   m;
		longint edge_v;

		sb = new();
		quiet_cycles = 0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		arst_n = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = CFG_MOD_ORDER;
		cfg_bus.data  = '0;
		sym_bus.valid         = 1'b0;
		sym_bus.sample_i      = '0;
		sym_bus.sample_q      = '0;
		sym_bus.chan_gain     = '0;
		sym_bus.end_of_packet = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: each constellation with channel gain in use
		cfg_write(CFG_USE_CSI, 2'd3);
		for (mi = 0; mi < 4; mi++) begin
			m = mod_t'(mi);
			drain();
			cfg_write(CFG_MOD_ORDER, m);
			case (m)
				MOD_QAM16: edge_v = demap_scoreboard::thr(GAIN_UNITY, K16_H1);
				MOD_QAM64: edge_v = demap_scoreboard::thr(GAIN_UNITY, K64_H3);
				MOD_QAM256: edge_v = demap_scoreboard::thr(GAIN_UNITY, K256_H4);
				default: edge_v = 0;
			endcase
			send_sym(16'sd0, 16'sd0, -16'sd4096, 1'b0);          // negative gain
			send_sym(SMP_MAX, SMP_MIN, 16'sd0, 1'b1);            // zero gain
			send_sym(SMP_MIN, SMP_MAX, SMP_MAX, 1'b0);           // largest gain
			send_sym(SMP_MIN, SMP_MIN, SMP_MIN, 1'b1);
			send_sym(smp_t'(edge_v), smp_t'(-edge_v), 16'sd4096, 1'b0);  // on the boundary
			send_sym(16'sd0, 16'sd0, 16'sd4096, 1'b1);           // zero symbol
			sym_stop();
		end

		for (mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					tx_idle_pct = 16;
					rx_idle_pct = 69;
				end
				1: begin
					tx_idle_pct = 69;
					rx_idle_pct = 16;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			drain();
			// writes to unmapped indexes must leave the settings alone
			cfg_write(CFG_IDX_SPARE_A, 2'($urandom));
			cfg_write(CFG_IDX_SPARE_B, 2'($urandom));
			for (mi = 0; mi < 4; mi++) begin
				for (csi = 0; csi < 2; csi++) begin
					m = mod_t'(mi);
					drain();
					cfg_write(CFG_MOD_ORDER, m);
					cfg_write(CFG_USE_CSI, {1'($urandom), 1'(csi)});
					random_burst(m, 1'(csi), ITEMS_PER_SETTING);
				end
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
